// File: rtl/loop_chunk_scheduler_core_macros.svh
// Assertion macros used by the checker file.
`ifndef LOOP_CHUNK_SCHEDULER_CORE_MACROS_SVH
`define LOOP_CHUNK_SCHEDULER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define LCS_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lcs check failed");

// Next-cycle implication, disabled while reset is high.
`define LCS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lcs check failed");

`endif

// File: rtl/lcs_pkg.sv
`default_nettype none
package lcs_pkg;

   localparam int MAX_THREADS = 64;
   localparam int POS_IDX_W   = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;

   localparam int POS_W    = 64;
   localparam int DIV_W    = 64;
   localparam int DIV_CNT_W = $clog2(DIV_W);
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_LOOP_START   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOP_UPPER   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_UB_OFFSET    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP         = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CHUNK_COUNT  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_THREAD_COUNT = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE         = 3'd6;

   localparam logic [1:0] MODE_STATIC  = 2'd0;
   localparam logic [1:0] MODE_DYNAMIC = 2'd1;
   localparam logic [1:0] MODE_GUIDED  = 2'd2;

   localparam logic ACT_START = 1'b0;
   localparam logic ACT_NEXT  = 1'b1;

   typedef struct packed {
      logic       action;
      logic [5:0] thread_id;
   } req_type;

   typedef struct packed {
      logic               got_chunk;
      logic signed [31:0] chunk_low;
      logic signed [31:0] chunk_high;
      logic               is_last;
   } rsp_type;

   typedef struct packed {
      logic                    clear;
      logic                    wr_en;
      logic [POS_IDX_W-1:0]    rd_idx;
      logic [POS_IDX_W-1:0]    wr_idx;
      logic signed [POS_W-1:0] wr_data;
   } pos_cmd_type;

endpackage
`default_nettype wire

// File: rtl/loop_chunk_scheduler_core.sv
// Loop chunk scheduler: one word in (start while not busy), one word out on rsp_valid.
// Guided requests take two 64-step passes of the shared radix-2 divider. The block takes no
// new word until the last result is out: the next word is accepted on the edge that takes
// the result, and the receiver never stalls it. Synchronous active-high reset clears control
// state, valid bits and configuration registers (step, chunk and thread count to 1).
`default_nettype none
module loop_chunk_scheduler_core (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   start,
   output logic                                  busy,
   input  wire  lcs_pkg::req_type                req_word,
   output logic                                  rsp_valid,
   output lcs_pkg::rsp_type                      rsp_word,
   input  wire                                   csr_wr_en,
   input  wire  [lcs_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire  [lcs_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import lcs_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_MUL_TID,
      ST_MUL_N,
      ST_STATIC_FIN,
      ST_SHARED_CHK,
      ST_DIV_SPAN,
      ST_DIV_ROUND,
      ST_SHARED_FIN
   } state_type;

   localparam int C_W      = 49;   // chunk_count * step
   localparam int STRIDE_W = 56;   // chunk * thread count or * thread id

   // ---------------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------------
   logic signed [31:0] loop_start_ff;
   logic signed [31:0] loop_upper_ff;
   logic signed [4:0]  ub_offset_ff;
   logic signed [31:0] step_ff;
   logic [15:0]        chunk_count_ff;
   logic [6:0]         thread_count_ff;
   logic [1:0]         mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         loop_start_ff   <= '0;
         loop_upper_ff   <= '0;
         ub_offset_ff    <= '0;
         step_ff         <= 32'sd1;
         chunk_count_ff  <= 16'd1;
         thread_count_ff <= 7'd1;
         mode_ff         <= MODE_STATIC;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_LOOP_START:   loop_start_ff   <= signed'(csr_wdata);
            CSR_LOOP_UPPER:   loop_upper_ff   <= signed'(csr_wdata);
            CSR_UB_OFFSET:    ub_offset_ff    <= signed'(csr_wdata[4:0]);
            CSR_STEP:         step_ff         <= signed'(csr_wdata);
            CSR_CHUNK_COUNT:  chunk_count_ff  <= csr_wdata[15:0];
            CSR_THREAD_COUNT: thread_count_ff <= csr_wdata[6:0];
            CSR_MODE:         mode_ff         <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // sequencer registers
   // ---------------------------------------------------------------------
   state_type                  state_ff, state_in;
   logic                       act_ff, act_in;
   logic [5:0]                 tid_ff, tid_in;
   logic signed [C_W-1:0]      c_ff, c_in;
   logic signed [STRIDE_W-1:0] prod_ff, prod_in;
   logic signed [STRIDE_W-1:0] stride_ff, stride_in;
   logic signed [POS_W-1:0]    b_ff, b_in;
   logic signed [POS_W-1:0]    e_ff, e_in;
   logic [DIV_W-1:0]           sum_ff, sum_in;
   logic signed [POS_W-1:0]    own_ff, own_in;
   logic                       own_set_ff, own_set_in;
   logic signed [POS_W-1:0]    shared_ff, shared_in;
   logic                       single_done_ff, single_done_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_type                    rsp_ff, rsp_in;

   // ---------------------------------------------------------------------
   // loop bounds and derived values
   // ---------------------------------------------------------------------
   logic signed [POS_W-1:0] lb64;
   logic signed [POS_W-1:0] ofs64;
   logic signed [POS_W-1:0] end64;
   logic signed [POS_W-1:0] c64;
   logic [DIV_W-1:0]        c_abs;
   logic                    c_neg;
   logic [15:0]             ch_eff;
   logic [6:0]              n_eff;
   logic                    tid_bad;
   logic                    mode_shared;

   always_comb begin
      lb64        = POS_W'(loop_start_ff);
      ofs64       = POS_W'(ub_offset_ff);
      end64       = POS_W'(loop_upper_ff) + ofs64;
      c64         = POS_W'(c_ff);
      c_neg       = c_ff[C_W-1];
      c_abs       = unsigned'(c_neg ? -c64 : c64);
      // zero chunk or thread count behaves as one
      ch_eff      = (chunk_count_ff == '0) ? 16'd1 : chunk_count_ff;
      n_eff       = (thread_count_ff == '0) ? 7'd1 : thread_count_ff;
      tid_bad     = int'(tid_ff) >= MAX_THREADS;
      mode_shared = (mode_ff == MODE_DYNAMIC) || (mode_ff == MODE_GUIDED);
   end

   // exhausted: at or past the end in the direction of the step
   function automatic logic past_end(input logic signed [POS_W-1:0] p,
                                     input logic                    neg,
                                     input logic signed [POS_W-1:0] lim);
      return neg ? (p <= lim) : (p >= lim);
   endfunction

   // ---------------------------------------------------------------------
   // shared multiplier: chunk size, then chunk * thread id, then stride
   // ---------------------------------------------------------------------
   logic signed [C_W-1:0]  mul_a;
   logic signed [16:0]     mul_b;
   logic signed [C_W+16:0] mul_p;

   always_comb begin
      unique case (state_ff)
         ST_MUL_TID: begin
            mul_a = c_ff;
            mul_b = signed'(17'(tid_ff));
         end
         ST_MUL_N: begin
            mul_a = c_ff;
            mul_b = signed'(17'(n_eff));
         end
         default: begin
            mul_a = C_W'(step_ff);
            mul_b = signed'(17'(ch_eff));
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // ---------------------------------------------------------------------
   // shared divider and position store
   // ---------------------------------------------------------------------
   logic             div_go;
   logic [DIV_W-1:0] div_dvd;
   logic [DIV_W-1:0] div_dvs;
   logic             div_done;
   logic [DIV_W-1:0] div_q;
   logic [DIV_W-1:0] div_r;

   lcs_div u_div (
      .clock     (clock),
      .reset     (reset),
      .go        (div_go),
      .dividend  (div_dvd),
      .divisor   (div_dvs),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   pos_cmd_type             pos_cmd;
   logic signed [POS_W-1:0] pos_rd;
   logic                    pos_rd_set;

   lcs_pos_ram u_pos (
      .clock  (clock),
      .reset  (reset),
      .cmd    (pos_cmd),
      .rd_pos (pos_rd),
      .rd_set (pos_rd_set)
   );

   // ---------------------------------------------------------------------
   // finishing a grant: clamp the end to the loop end, drop the offset
   // ---------------------------------------------------------------------
   logic signed [POS_W-1:0] fin_e;
   logic                    fin_last;
   logic signed [POS_W-1:0] fin_hi;
   logic signed [POS_W-1:0] fin_hi_ofs;
   logic signed [POS_W-1:0] static_next;
   logic signed [POS_W-1:0] own_pos;
   logic [DIV_W-1:0]        span_mag;
   logic [DIV_W-1:0]        round_mag;
   rsp_type                 grant;

   always_comb begin
      fin_e       = (state_ff == ST_STATIC_FIN) ? (b_ff + c64) : e_ff;
      fin_last    = past_end(fin_e, c_neg, end64);
      fin_hi      = fin_last ? end64 : fin_e;
      fin_hi_ofs  = fin_hi - ofs64;
      static_next = b_ff + POS_W'(stride_ff);
      own_pos     = own_set_ff ? own_ff : lb64;
      // guided: |end - pos| / threads, then round (that + chunk) down to a chunk
      span_mag    = c_neg ? unsigned'(shared_ff - end64) : unsigned'(end64 - shared_ff);
      round_mag   = sum_ff - div_r;

      grant.got_chunk  = 1'b1;
      grant.chunk_low  = b_ff[31:0];
      grant.chunk_high = fin_hi_ofs[31:0];
      grant.is_last    = fin_last;
   end

   // ---------------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      state_in       = state_ff;
      act_in         = act_ff;
      tid_in         = tid_ff;
      c_in           = c_ff;
      prod_in        = prod_ff;
      stride_in      = stride_ff;
      b_in           = b_ff;
      e_in           = e_ff;
      sum_in         = sum_ff;
      own_in         = own_ff;
      own_set_in     = own_set_ff;
      shared_in      = shared_ff;
      single_done_in = single_done_ff;
      rsp_valid_in   = 1'b0;
      rsp_in         = rsp_ff;

      div_go  = 1'b0;
      div_dvd = span_mag;
      div_dvs = DIV_W'(n_eff);

      pos_cmd         = '0;
      pos_cmd.rd_idx  = POS_IDX_W'(tid_ff);
      pos_cmd.wr_idx  = POS_IDX_W'(tid_ff);
      pos_cmd.wr_data = e_ff;

      unique case (state_ff)
         ST_IDLE: begin
            // read the thread position while the word is being latched
            pos_cmd.rd_idx = POS_IDX_W'(req_word.thread_id);
            if (start) begin
               act_in   = req_word.action;
               tid_in   = req_word.thread_id;
               state_in = ST_DECODE;
            end
         end

         ST_DECODE: begin
            rsp_in = '0;
            if (act_ff == ACT_START) begin
               shared_in      = lb64;
               single_done_in = 1'b0;
               pos_cmd.clear  = 1'b1;
               rsp_valid_in   = 1'b1;
               state_in       = ST_IDLE;
            end else if (tid_bad) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else if (n_eff == 7'd1) begin
               // single thread: the whole range once
               if (!single_done_ff && (lb64 != end64)) begin
                  single_done_in    = 1'b1;
                  rsp_in.got_chunk  = 1'b1;
                  rsp_in.chunk_low  = loop_start_ff;
                  rsp_in.chunk_high = loop_upper_ff;
                  rsp_in.is_last    = 1'b1;
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else if (step_ff == '0) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               c_in       = mul_p[C_W-1:0];
               own_in     = pos_rd;
               own_set_in = pos_rd_set;
               state_in   = mode_shared ? ST_SHARED_CHK : ST_MUL_TID;
            end
         end

         ST_MUL_TID: begin
            prod_in  = mul_p[STRIDE_W-1:0];
            state_in = ST_MUL_N;
         end

         ST_MUL_N: begin
            stride_in = mul_p[STRIDE_W-1:0];
            b_in      = own_set_ff ? own_ff : (lb64 + POS_W'(prod_ff));
            state_in  = ST_STATIC_FIN;
         end

         ST_STATIC_FIN: begin
            pos_cmd.wr_en = 1'b1;
            if (past_end(b_ff, c_neg, end64)) begin
               // park the exhausted position
               pos_cmd.wr_data = b_ff;
               rsp_in          = '0;
            end else begin
               pos_cmd.wr_data = static_next;
               rsp_in          = grant;
            end
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end

         ST_SHARED_CHK: begin
            b_in = shared_ff;
            if (past_end(shared_ff, c_neg, end64)) begin
               rsp_in       = '0;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else if (mode_ff == MODE_GUIDED) begin
               div_go   = 1'b1;
               state_in = ST_DIV_SPAN;
            end else begin
               e_in     = shared_ff + c64;
               state_in = ST_SHARED_FIN;
            end
         end

         ST_DIV_SPAN: begin
            div_dvd = div_q + c_abs;
            div_dvs = c_abs;
            if (div_done) begin
               sum_in   = div_q + c_abs;
               div_go   = 1'b1;
               state_in = ST_DIV_ROUND;
            end
         end

         ST_DIV_ROUND: begin
            if (div_done) begin
               e_in     = c_neg ? (b_ff - signed'(round_mag)) : (b_ff + signed'(round_mag));
               state_in = ST_SHARED_FIN;
            end
         end

         ST_SHARED_FIN: begin
            // the shared position advances even if this thread is done
            shared_in = e_ff;
            if (past_end(own_pos, c_neg, end64)) begin
               rsp_in = '0;
            end else begin
               pos_cmd.wr_en = 1'b1;
               rsp_in        = grant;
            end
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         act_ff         <= ACT_START;
         tid_ff         <= '0;
         own_set_ff     <= 1'b0;
         shared_ff      <= '0;
         single_done_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         rsp_ff         <= '0;
      end else begin
         state_ff       <= state_in;
         act_ff         <= act_in;
         tid_ff         <= tid_in;
         own_set_ff     <= own_set_in;
         shared_ff      <= shared_in;
         single_done_ff <= single_done_in;
         rsp_valid_ff   <= rsp_valid_in;
         rsp_ff         <= rsp_in;
      end
      c_ff      <= c_in;
      prod_ff   <= prod_in;
      stride_ff <= stride_in;
      b_ff      <= b_in;
      e_ff      <= e_in;
      sum_ff    <= sum_in;
      own_ff    <= own_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule
`default_nettype wire

// File: rtl/lcs_div.sv
`default_nettype none
module lcs_div (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        go,
   input  wire  [lcs_pkg::DIV_W-1:0]  dividend,
   input  wire  [lcs_pkg::DIV_W-1:0]  divisor,
   output logic                       done,
   output logic [lcs_pkg::DIV_W-1:0]  quotient,
   output logic [lcs_pkg::DIV_W-1:0]  remainder
);
   import lcs_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DIV_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]     dvs_ff, dvs_in;
   logic [DIV_W:0]       rem_sh;
   logic [DIV_W:0]       diff;
   logic                 fits;

   // one restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      rem_sh = {rem_ff, quo_ff[DIV_W-1]};
      diff   = rem_sh - {1'b0, dvs_ff};
      fits   = !diff[DIV_W];
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (go) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_W - 1);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIV_W-2:0], fits};
         rem_in = fits ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule
`default_nettype wire

// File: rtl/lcs_pos_ram.sv
`default_nettype none
module lcs_pos_ram (
   input  wire                               clock,
   input  wire                               reset,
   input  wire  lcs_pkg::pos_cmd_type        cmd,
   output logic signed [lcs_pkg::POS_W-1:0]  rd_pos,
   output logic                              rd_set
);
   import lcs_pkg::*;

   logic signed [POS_W-1:0] mem [MAX_THREADS];
   logic [MAX_THREADS-1:0]  set_ff;
   logic signed [POS_W-1:0] rd_pos_ff;
   logic                    rd_set_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_idx] <= cmd.wr_data;
      end
      rd_pos_ff <= mem[cmd.rd_idx];
   end

   // position valid bits: a start drops them all at once
   always_ff @(posedge clock) begin
      if (reset) begin
         set_ff    <= '0;
         rd_set_ff <= 1'b0;
      end else begin
         if (cmd.clear) begin
            set_ff <= '0;
         end else if (cmd.wr_en) begin
            set_ff[cmd.wr_idx] <= 1'b1;
         end
         rd_set_ff <= set_ff[cmd.rd_idx];
      end
   end

   assign rd_pos = rd_pos_ff;
   assign rd_set = rd_set_ff;

endmodule
`default_nettype wire

// File: rtl/lcs_checker.sv
`default_nettype none
`include "loop_chunk_scheduler_core_macros.svh"
module lcs_checker (
   input wire              clock,
   input wire              reset,
   input wire              start,
   input wire              busy,
   input wire              rsp_valid,
   input wire lcs_pkg::rsp_type rsp_word
);
   import lcs_pkg::*;

   logic rsp_zero;

   assign rsp_zero = (rsp_word.chunk_low == 32'sd0) && (rsp_word.chunk_high == 32'sd0)
                     && !rsp_word.is_last;

   // an accepted word always takes the block busy
   `LCS_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   // a result shows only once the block is free again
   `LCS_ASSERT_SAME(a_rsp_idle, clock, reset, rsp_valid, !busy)
   // one strobe per word
   `LCS_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid)
   // no grant means empty fields
   `LCS_ASSERT_SAME(a_rsp_empty, clock, reset, rsp_valid && !rsp_word.got_chunk, rsp_zero)

endmodule

bind loop_chunk_scheduler_core lcs_checker u_lcs_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_word  (rsp_word)
);
`default_nettype wire
